FILE: rtl/rtlg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rtlg_pkg;

  localparam int GRID_WIDTH       = 256;
  localparam int GRID_HEIGHT      = 256;
  localparam int NOISE_MAX_RADIUS = 4;
  localparam int CELL_COUNT       = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W           = $clog2(CELL_COUNT);
  localparam int X_W              = $clog2(GRID_WIDTH);
  localparam int Y_W              = $clog2(GRID_HEIGHT);
  localparam int NUM_BOUNDS       = 50;

  localparam logic [6:0] PROB_HALF = 7'd50;

  localparam logic [14:0] PROB_BOUNDS [NUM_BOUNDS] = '{
    15'd82,    15'd246,   15'd410,   15'd575,   15'd740,
    15'd905,   15'd1072,  15'd1239,  15'd1407,  15'd1576,
    15'd1747,  15'd1919,  15'd2093,  15'd2269,  15'd2446,
    15'd2626,  15'd2809,  15'd2994,  15'd3182,  15'd3374,
    15'd3569,  15'd3768,  15'd3971,  15'd4179,  15'd4392,
    15'd4610,  15'd4835,  15'd5066,  15'd5305,  15'd5552,
    15'd5808,  15'd6074,  15'd6352,  15'd6642,  15'd6947,
    15'd7268,  15'd7609,  15'd7971,  15'd8359,  15'd8778,
    15'd9233,  15'd9734,  15'd10291, 15'd10921, 15'd11649,
    15'd12514, 15'd13586, 15'd15006, 15'd17141, 15'd21682
  };

  typedef enum logic [2:0] {
    CFG_FREE_INC   = 3'd0,
    CFG_OCC_INC    = 3'd1,
    CFG_DIST_FACT  = 3'd2,
    CFG_NOISE_RSQ  = 3'd3,
    CFG_NOISE_W    = 3'd4
  } rtlg_cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] free_inc;
    logic signed [15:0] occ_inc;
    logic [15:0]        dist_factor;
    logic [4:0]         noise_rsq;
    logic [15:0]        noise_w;
  } rtlg_cfg_t;

  // one queued request, already decoded by the front end
  typedef struct packed {
    logic              is_read;
    logic              rd_in_grid;
    logic [ADDR_W-1:0] rd_addr;
    logic signed [10:0] sx;
    logic signed [10:0] sy;
    logic signed [10:0] ex;
    logic signed [10:0] ey;
    logic [10:0]       adx;
    logic [10:0]       ady;
    logic              stx_neg;
    logic              sty_neg;
    logic              hit;
  } rtlg_item_t;

  function automatic logic in_grid(logic signed [11:0] x, logic signed [11:0] y);
    return !x[11] && !y[11] && (x < 12'(GRID_WIDTH)) && (y < 12'(GRID_HEIGHT));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [11:0] x, logic [11:0] y);
    return ADDR_W'(ADDR_W'(y[Y_W-1:0]) * ADDR_W'(GRID_WIDTH) + ADDR_W'(x[X_W-1:0]));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rtlg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module rtlg_front import rtlg_pkg::*; (
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic signed [10:0] start_x_i,
  input  wire logic signed [10:0] start_y_i,
  input  wire logic signed [10:0] end_x_i,
  input  wire logic signed [10:0] end_y_i,
  input  wire logic               hit_i,
  input  wire logic [7:0]         cell_x_i,
  input  wire logic [7:0]         cell_y_i,
  input  wire logic               q_full_i,
  input  wire logic               clearing_i,
  output logic                    push_o,
  output rtlg_item_t              item_o
);

  logic signed [11:0] dx;
  logic signed [11:0] dy;

  assign in_stall_o = q_full_i || clearing_i;
  assign push_o     = in_valid_i && !in_stall_o;

  always_comb begin
    dx = 12'(end_x_i) - 12'(start_x_i);
    dy = 12'(end_y_i) - 12'(start_y_i);
    item_o.is_read    = req_type_i;
    item_o.rd_in_grid = in_grid({4'b0, cell_x_i}, {4'b0, cell_y_i});
    item_o.rd_addr    = cell_addr({4'b0, cell_x_i}, {4'b0, cell_y_i});
    item_o.sx         = start_x_i;
    item_o.sy         = start_y_i;
    item_o.ex         = end_x_i;
    item_o.ey         = end_y_i;
    item_o.adx        = dx[11] ? 11'(-dx) : dx[10:0];
    item_o.ady        = dy[11] ? 11'(-dy) : dy[10:0];
    item_o.stx_neg    = !(start_x_i < end_x_i);
    item_o.sty_neg    = !(start_y_i < end_y_i);
    item_o.hit        = hit_i;
  end

endmodule
`default_nettype wire

FILE: rtl/rtlg_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module rtlg_queue import rtlg_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  rtlg_item_t      item_i,
  input  wire logic       pop_i,
  output rtlg_item_t      item_o,
  output logic            full_o,
  output logic            empty_o
);

  rtlg_item_t  slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rtlg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module rtlg_back import rtlg_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  rtlg_cfg_t   cfg_i,
  input  rtlg_item_t  item_i,
  input  wire logic   item_avail_i,
  output logic        item_pop_o,
  output logic        clearing_o,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output logic        cell_known_o,
  output logic [6:0]  cell_probability_o,
  output logic [11:0] cells_updated_o
);

  typedef enum logic [17:0] {
    ST_CLEAR = 18'h00001,
    ST_IDLE  = 18'h00002,
    ST_RRD   = 18'h00004,
    ST_RCMP  = 18'h00008,
    ST_RCNT  = 18'h00010,
    ST_D2    = 18'h00020,
    ST_SQRT  = 18'h00040,
    ST_SMUL  = 18'h00080,
    ST_SCL   = 18'h00100,
    ST_FINC  = 18'h00200,
    ST_LINE  = 18'h00400,
    ST_LWR   = 18'h00800,
    ST_DSEL  = 18'h01000,
    ST_DW    = 18'h02000,
    ST_DM1   = 18'h04000,
    ST_DM2   = 18'h08000,
    ST_DWR   = 18'h10000,
    ST_DONE  = 18'h20000
  } rtlg_state_e;

  localparam logic signed [4:0] R_POS = 5'(NOISE_MAX_RADIUS);
  localparam logic signed [4:0] R_NEG = 5'(-NOISE_MAX_RADIUS);

  rtlg_state_e state_q, state_d;
  rtlg_item_t  item_q, item_d;

  logic [16:0]        mem_q [CELL_COUNT];
  logic [16:0]        rd_q;
  logic               mem_re, mem_we;
  logic [ADDR_W-1:0]  mem_raddr, mem_waddr;
  logic [16:0]        mem_wdata;
  logic [ADDR_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic [ADDR_W-1:0]  waddr_q, waddr_d;

  logic [39:0]        n_q, n_d;
  logic [23:0]        rem_q, rem_d;
  logic [19:0]        root_q, root_d;
  logic [4:0]         sq_cnt_q, sq_cnt_d;
  logic [35:0]        prod_q, prod_d;
  logic signed [17:0] scale_q, scale_d;
  logic signed [17:0] inc_q, inc_d;
  logic signed [17:0] free_inc_q, free_inc_d;
  logic signed [17:0] inc1_q, inc1_d;
  logic signed [10:0] x_q, x_d, y_q, y_d;
  logic signed [13:0] err_q, err_d;
  logic signed [4:0]  ox_q, ox_d, oy_q, oy_d;
  logic [16:0]        w_q, w_d;
  logic [4:0]         k_q, k_d;
  logic [11:0]        cnt_q, cnt_d;
  logic [NUM_BOUNDS-1:0] ge_q, ge_d;
  logic               known_q, known_d;
  logic               neg_q, neg_d;
  logic               pend_known_q, pend_known_d;
  logic [6:0]         pend_prob_q, pend_prob_d;

  logic               res_valid_q, res_valid_d;
  logic               res_known_q, res_known_d;
  logic [6:0]         res_prob_q, res_prob_d;
  logic [11:0]        res_cnt_q, res_cnt_d;

  // combinational helpers
  logic signed [14:0] e2;
  logic               step_x, step_y, line_end;
  logic signed [14:0] err_step;
  logic signed [11:0] disc_x, disc_y;
  logic [7:0]         disc_q;
  logic               disc_last;
  logic signed [15:0] rd_val;
  logic signed [18:0] sum;
  logic [15:0]        sat_val;
  logic [23:0]        sq_cat, sq_trial;
  logic [22:0]        d2;
  logic [36:0]        t_sum;
  logic [27:0]        t_len;
  logic [28:0]        scale_w;
  logic signed [33:0] p_fi, p_oc;
  logic signed [35:0] p_sc;
  logic [32:0]        w_prod;
  logic [16:0]        abs_l;
  logic [5:0]         n_ge;

  assign clearing_o         = state_q == ST_CLEAR;
  assign out_valid_o        = res_valid_q;
  assign cell_known_o       = res_known_q;
  assign cell_probability_o = res_prob_q;
  assign cells_updated_o    = res_cnt_q;
  assign item_pop_o         = (state_q == ST_IDLE) && item_avail_i;

  always_comb begin
    e2       = {err_q, 1'b0};
    step_x   = e2 >= -$signed({4'b0, item_q.ady});
    step_y   = e2 <= $signed({4'b0, item_q.adx});
    err_step = 15'(err_q) - (step_x ? $signed({4'b0, item_q.ady}) : 15'sd0)
                          + (step_y ? $signed({4'b0, item_q.adx}) : 15'sd0);
    line_end = (x_q == item_q.ex) && (y_q == item_q.ey);

    disc_x    = 12'(item_q.ex) + 12'(ox_q);
    disc_y    = 12'(item_q.ey) + 12'(oy_q);
    disc_q    = 8'(ox_q) * 8'(ox_q) + 8'(oy_q) * 8'(oy_q);
    disc_last = (ox_q == R_POS) && (oy_q == R_POS);

    rd_val  = rd_q[16] ? $signed(rd_q[15:0]) : 16'sd0;
    sum     = 19'(rd_val) + 19'(inc_q);
    if (sum > 19'sd32767) begin
      sat_val = 16'h7fff;
    end else if (sum < -19'sd32768) begin
      sat_val = 16'h8000;
    end else begin
      sat_val = sum[15:0];
    end

    sq_cat   = {rem_q[21:0], n_q[39:38]};
    sq_trial = {2'b0, root_q, 2'b01};
    d2       = 23'(22'(item_q.adx) * 22'(item_q.adx)) + 23'(22'(item_q.ady) * 22'(item_q.ady));
    t_sum    = 37'(prod_q) + 37'd128;
    t_len    = t_sum[35:8];
    scale_w  = 29'd65536 - {1'b0, t_len};
    p_fi     = $signed(cfg_i.free_inc) * scale_q;
    p_oc     = $signed(cfg_i.occ_inc) * $signed({1'b0, w_q});
    p_sc     = inc1_q * scale_q;
    w_prod   = 33'(w_q) * 33'(cfg_i.noise_w) + 33'd32768;

    abs_l = rd_val[15] ? 17'(-17'(rd_val)) : 17'(rd_val);
    n_ge  = '0;
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      n_ge = n_ge + 6'(ge_q[i]);
    end
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    clr_cnt_d    = clr_cnt_q;
    waddr_d      = waddr_q;
    n_d          = n_q;
    rem_d        = rem_q;
    root_d       = root_q;
    sq_cnt_d     = sq_cnt_q;
    prod_d       = prod_q;
    scale_d      = scale_q;
    inc_d        = inc_q;
    free_inc_d   = free_inc_q;
    inc1_d       = inc1_q;
    x_d          = x_q;
    y_d          = y_q;
    err_d        = err_q;
    ox_d         = ox_q;
    oy_d         = oy_q;
    w_d          = w_q;
    k_d          = k_q;
    cnt_d        = cnt_q;
    ge_d         = ge_q;
    known_d      = known_q;
    neg_d        = neg_q;
    pend_known_d = pend_known_q;
    pend_prob_d  = pend_prob_q;
    res_valid_d  = res_valid_q && out_stall_i;
    res_known_d  = res_known_q;
    res_prob_d   = res_prob_q;
    res_cnt_d    = res_cnt_q;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_raddr    = waddr_q;
    mem_waddr    = waddr_q;
    mem_wdata    = {1'b1, sat_val};

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_avail_i) begin
          item_d  = item_i;
          state_d = item_i.is_read ? ST_RRD : ST_D2;
        end
      end
      ST_RRD: begin
        mem_re    = 1'b1;
        mem_raddr = item_q.rd_addr;
        state_d   = ST_RCMP;
      end
      ST_RCMP: begin
        known_d = rd_q[16] && item_q.rd_in_grid;
        neg_d   = rd_val[15];
        for (int i = 0; i < NUM_BOUNDS; i++) begin
          ge_d[i] = abs_l >= {2'b0, PROB_BOUNDS[i]};
        end
        state_d = ST_RCNT;
      end
      ST_RCNT: begin
        pend_known_d = known_q;
        if (!known_q) begin
          pend_prob_d = '0;
        end else if (neg_q) begin
          pend_prob_d = PROB_HALF - 7'(n_ge);
        end else begin
          pend_prob_d = PROB_HALF + 7'(n_ge);
        end
        cnt_d   = '0;
        state_d = ST_DONE;
      end
      ST_D2: begin
        n_d      = {1'b0, d2, 16'b0};
        rem_d    = '0;
        root_d   = '0;
        sq_cnt_d = 5'd19;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        // one result bit per cycle
        if (sq_cat >= sq_trial) begin
          rem_d  = sq_cat - sq_trial;
          root_d = {root_q[18:0], 1'b1};
        end else begin
          rem_d  = sq_cat;
          root_d = {root_q[18:0], 1'b0};
        end
        n_d      = {n_q[37:0], 2'b00};
        sq_cnt_d = sq_cnt_q - 1'b1;
        if (sq_cnt_q == '0) begin
          state_d = ST_SMUL;
        end
      end
      ST_SMUL: begin
        prod_d  = 36'(cfg_i.dist_factor) * 36'(root_q);
        state_d = ST_SCL;
      end
      ST_SCL: begin
        if (t_len > 28'd196608) begin
          scale_d = -18'sd131072;
        end else begin
          scale_d = scale_w[17:0];
        end
        state_d = ST_FINC;
      end
      ST_FINC: begin
        free_inc_d = 18'((p_fi + 34'sd32768) >>> 16);
        x_d        = item_q.sx;
        y_d        = item_q.sy;
        err_d      = 14'(item_q.adx) - 14'(item_q.ady);
        ox_d       = R_NEG;
        oy_d       = R_NEG;
        cnt_d      = '0;
        state_d    = ST_LINE;
      end
      ST_LINE, ST_LWR: begin
        inc_d = free_inc_q;
        if (state_q == ST_LINE && in_grid(12'(x_q), 12'(y_q))) begin
          mem_re    = 1'b1;
          mem_raddr = cell_addr(12'(x_q), 12'(y_q));
          waddr_d   = mem_raddr;
          state_d   = ST_LWR;
        end else begin
          if (state_q == ST_LWR) begin
            mem_we = 1'b1;
            if (cnt_q != 12'hfff) cnt_d = cnt_q + 1'b1;
          end
          // advance along the line
          if (line_end) begin
            state_d = item_q.hit ? ST_DSEL : ST_DONE;
          end else begin
            err_d = err_step[13:0];
            if (step_x) x_d = item_q.stx_neg ? x_q - 11'sd1 : x_q + 11'sd1;
            if (step_y) y_d = item_q.sty_neg ? y_q - 11'sd1 : y_q + 11'sd1;
            state_d = ST_LINE;
          end
        end
      end
      ST_DSEL, ST_DWR: begin
        if (state_q == ST_DSEL && disc_q <= {3'b0, cfg_i.noise_rsq}
            && in_grid(disc_x, disc_y)) begin
          waddr_d = cell_addr(disc_x, disc_y);
          w_d     = 17'd65536;
          k_d     = disc_q[4:0];
          state_d = ST_DW;
        end else begin
          if (state_q == ST_DWR) begin
            mem_we = 1'b1;
            if (cnt_q != 12'hfff) cnt_d = cnt_q + 1'b1;
          end
          if (disc_last) begin
            state_d = ST_DONE;
          end else begin
            if (ox_q == R_POS) begin
              ox_d = R_NEG;
              oy_d = oy_q + 5'sd1;
            end else begin
              ox_d = ox_q + 5'sd1;
            end
            state_d = ST_DSEL;
          end
        end
      end
      ST_DW: begin
        if (k_q == '0) begin
          state_d = ST_DM1;
        end else begin
          w_d = w_prod[32:16];
          k_d = k_q - 1'b1;
        end
      end
      ST_DM1: begin
        inc1_d  = 18'((p_oc + 34'sd32768) >>> 16);
        state_d = ST_DM2;
      end
      ST_DM2: begin
        inc_d   = 18'((p_sc + 36'sd32768) >>> 16);
        mem_re  = 1'b1;
        state_d = ST_DWR;
      end
      ST_DONE: begin
        if (!res_valid_q || !out_stall_i) begin
          res_valid_d = 1'b1;
          res_known_d = item_q.is_read ? pend_known_q : 1'b0;
          res_prob_d  = item_q.is_read ? pend_prob_q : 7'd0;
          res_cnt_d   = item_q.is_read ? 12'd0 : cnt_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      res_valid_q <= 1'b0;
      sq_cnt_q    <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      err_q       <= '0;
      scale_q     <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      res_valid_q <= res_valid_d;
      sq_cnt_q    <= sq_cnt_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      scale_q     <= scale_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    waddr_q      <= waddr_d;
    n_q          <= n_d;
    rem_q        <= rem_d;
    root_q       <= root_d;
    prod_q       <= prod_d;
    inc_q        <= inc_d;
    free_inc_q   <= free_inc_d;
    inc1_q       <= inc1_d;
    x_q          <= x_d;
    y_q          <= y_d;
    ox_q         <= ox_d;
    oy_q         <= oy_d;
    w_q          <= w_d;
    ge_q         <= ge_d;
    known_q      <= known_d;
    neg_q        <= neg_d;
    pend_known_q <= pend_known_d;
    pend_prob_q  <= pend_prob_d;
    res_known_q  <= res_known_d;
    res_prob_q   <= res_prob_d;
    res_cnt_q    <= res_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_o |-> state_q == ST_IDLE)
    else $error("item popped while engine busy");

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !item_pop_o && !out_valid_o)
    else $error("activity during clearing pass");

  a_line_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LWR |-> $past(state_q == ST_LINE))
    else $error("line write without preceding read");

  a_disc_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DWR |-> $past(state_q == ST_DM2))
    else $error("disc write without preceding read");

endmodule
`default_nettype wire

FILE: rtl/ray_trace_log_odds_grid_update_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Read: the cell word is read, compared with the bound table and turned into a result word.
// Trace: a bit-serial square root (20 result bits), then a read and write-back per in-grid
// line cell, a step per off-grid cell, then with hit a weight, read and write per disc cell.
// One item at a time in the engine; a 2-word queue takes new words meanwhile.
// Reset: after rst_ni the grid memory is cleared, all 65536 cells, one cell a cycle,
// input stalled throughout; configuration writes are taken at any time.
module ray_trace_log_odds_grid_update_top import rtlg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               req_type_i,
  input  wire logic signed [10:0] start_x_i,
  input  wire logic signed [10:0] start_y_i,
  input  wire logic signed [10:0] end_x_i,
  input  wire logic signed [10:0] end_y_i,
  input  wire logic               hit_i,
  input  wire logic [7:0]         cell_x_i,
  input  wire logic [7:0]         cell_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    cell_known_o,
  output logic [6:0]              cell_probability_o,
  output logic [11:0]             cells_updated_o
);

  rtlg_cfg_t  cfg_q, cfg_d;
  rtlg_item_t front_item, q_item;
  logic       push, pop, q_full, q_empty, clearing;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FREE_INC:  cfg_d.free_inc    = cfg_data_i;
        CFG_OCC_INC:   cfg_d.occ_inc     = cfg_data_i;
        CFG_DIST_FACT: cfg_d.dist_factor = cfg_data_i;
        CFG_NOISE_RSQ: cfg_d.noise_rsq   = cfg_data_i[4:0];
        CFG_NOISE_W:   cfg_d.noise_w     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.free_inc    <= -16'sd3470;
      cfg_q.occ_inc     <= 16'sd3470;
      cfg_q.dist_factor <= 16'd0;
      cfg_q.noise_rsq   <= 5'd1;
      cfg_q.noise_w     <= 16'd32768;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rtlg_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .hit_i      (hit_i),
    .cell_x_i   (cell_x_i),
    .cell_y_i   (cell_y_i),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .push_o     (push),
    .item_o     (front_item)
  );

  rtlg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .item_o  (q_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rtlg_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .item_i             (q_item),
    .item_avail_i       (!q_empty),
    .item_pop_o         (pop),
    .clearing_o         (clearing),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .cell_known_o       (cell_known_o),
    .cell_probability_o (cell_probability_o),
    .cells_updated_o    (cells_updated_o)
  );

endmodule
`default_nettype wire
